// ===== rtl/cht_pkg.sv =====
package cht_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPSERT = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam int KEY_W    = 64;
  localparam int HASH_W   = 32;
  localparam int VAL_IO_W = 32;
  localparam int SLOT_O_W = 8;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_RD_MAIN,
    S_CHK_MAIN,
    S_RD_CUR,
    S_CHK_CUR,
    S_SET_DEC,
    S_TAIL_RD,
    S_TAIL_CHK,
    S_EVICT_RD,
    S_EVICT_CHK,
    S_EVICT_WR,
    S_RM_DEC,
    S_RM_PULL_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_FREE_SCAN,
    S_OUT
  } state_t;

endpackage

// ===== rtl/cht_if.sv =====
interface cht_in_if;
  import cht_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic signed [63:0]  key;
  logic [31:0]         hash;
  logic [31:0]         value;
  modport source (output valid, command, key, hash, value, input ready);
  modport sink (input valid, command, key, hash, value, output ready);
endinterface

interface cht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [7:0]  slot_index;
  modport source (output valid, status, found_value, slot_index, input ready);
  modport sink (input valid, status, found_value, slot_index, output ready);
endinterface

// ===== rtl/cht_store.sv =====
module cht_store
  import cht_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int VW = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [KEY_W-1:0]  wkey,
  input  logic [HASH_W-1:0] whash,
  input  logic [VW-1:0]     wval,
  input  logic [AW:0]       wnext,
  input  logic [AW-1:0]     raddr,
  output logic [KEY_W-1:0]  rkey,
  output logic [HASH_W-1:0] rhash,
  output logic [VW-1:0]     rval,
  output logic [AW:0]       rnext
);
  logic [KEY_W-1:0]  key_mem  [DEPTH];
  logic [HASH_W-1:0] hash_mem [DEPTH];
  logic [VW-1:0]     val_mem  [DEPTH];
  logic [AW:0]       next_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]  <= wkey;
      hash_mem[waddr] <= whash;
      val_mem[waddr]  <= wval;
      next_mem[waddr] <= wnext;
    end
    rkey  <= key_mem[raddr];
    rhash <= hash_mem[raddr];
    rval  <= val_mem[raddr];
    rnext <= next_mem[raddr];
  end
endmodule

// ===== rtl/coalesced_hash_table.sv =====
// channel | dir | fields
// in_*    | in  | command, key, hash, value
// out_*   | out | status, found_value, slot_index
// one item at a time: after the accept edge the sequencer reads and checks the main
// slot, then walks the chain entries, takes its write steps and steps slot by slot
// through the lowest-free scan as needed; the single store read port sets this pace
// after reset a clearing pass writes every slot before in_ready rises
// the result sits in an output register; out_ready low stalls the next item
module coalesced_hash_table
  import cht_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int VALUE_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  cht_in_if.sink   in_ch,
  cht_out_if.source out_ch
);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [AW:0] NO_SLOT = (AW+1)'(CAPACITY);

  state_t st_r, st_nxt;
  logic [CAPACITY-1:0] vld_r;
  logic [AW:0] free_r, free_nxt;
  logic [AW:0] cnt_r, cnt_nxt;
  logic [1:0] cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [HASH_W-1:0] hash_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [AW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, at_r, at_nxt;
  logic has_prev_r, has_prev_nxt;
  logic [1:0] ost_r, ost_nxt;
  logic [VAL_IO_W-1:0] ofv_r, ofv_nxt;
  logic [AW-1:0] oslot_r, oslot_nxt;
  logic ovalid_r, ovalid_nxt;
  // saved copy of an entry for evict / unlink
  logic [KEY_W-1:0] sk_r, sk_nxt;
  logic [HASH_W-1:0] sh_r, sh_nxt;
  logic [VALUE_WIDTH-1:0] sv_r, sv_nxt;
  logic [AW:0] sn_r, sn_nxt;
  logic [AW-1:0] nx_r, nx_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [KEY_W-1:0] wkey, rkey;
  logic [HASH_W-1:0] whash, rhash;
  logic [VALUE_WIDTH-1:0] wval, rval;
  logic [AW:0] wnext, rnext;
  logic vset, vclr;
  logic [AW-1:0] vaddr;

  cht_store #(.DEPTH(CAPACITY), .VW(VALUE_WIDTH)) u_store (
    .clk, .we, .waddr, .wkey, .whash, .wval, .wnext,
    .raddr, .rkey, .rhash, .rval, .rnext
  );

  logic [AW-1:0] pos;
  logic hit, nxt_ok;
  assign pos = hash_r[AW-1:0];
  assign hit = (rhash == hash_r) && (rkey == key_r);
  assign nxt_ok = (rnext < NO_SLOT) && vld_r[rnext[AW-1:0]];

  assign in_ch.ready = (st_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.status = ost_r;
  assign out_ch.found_value = ofv_r;
  assign out_ch.slot_index = SLOT_O_W'({{(16){1'b0}}, oslot_r});

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLEAR:      if (cnt_r == NO_SLOT - 1'b1) st_nxt = S_IDLE;
      S_IDLE:       if (in_ch.valid && in_ch.ready) st_nxt = S_RD_MAIN;
      S_RD_MAIN:    st_nxt = S_CHK_MAIN;
      S_CHK_MAIN: begin
        if (!vld_r[pos]) st_nxt = (cmd_r[1]) ? S_OUT :
                                  ((free_r == {1'b0, pos}) ? S_FREE_RD : S_OUT);
        else if (rhash[AW-1:0] != pos) st_nxt = cmd_r[1] ? S_OUT : S_SET_DEC;
        else st_nxt = S_RD_CUR;
      end
      S_RD_CUR:     st_nxt = S_CHK_CUR;
      S_CHK_CUR: begin
        if (hit) begin
          if (cmd_r == CMD_REMOVE) st_nxt = S_RM_DEC;
          else st_nxt = S_OUT;
        end else if (nxt_ok && cnt_r != NO_SLOT - 1'b1) st_nxt = S_RD_CUR;
        else st_nxt = cmd_r[1] ? S_OUT : S_SET_DEC;
      end
      S_SET_DEC: begin
        if (free_r == NO_SLOT) st_nxt = S_OUT;
        else if (rhash[AW-1:0] != pos) st_nxt = S_EVICT_RD;
        else st_nxt = S_TAIL_RD;
      end
      S_TAIL_RD:    st_nxt = S_TAIL_CHK;
      S_TAIL_CHK:   st_nxt = (nxt_ok && cnt_r != NO_SLOT - 1'b1) ? S_TAIL_RD : S_FREE_RD;
      S_EVICT_RD:   st_nxt = S_EVICT_CHK;
      S_EVICT_CHK: begin
        if (rnext == {1'b0, pos} || rnext >= NO_SLOT || cnt_r == NO_SLOT - 1'b1)
          st_nxt = S_EVICT_WR;
        else st_nxt = S_EVICT_RD;
      end
      S_EVICT_WR:   st_nxt = S_FREE_RD;
      S_RM_DEC:     st_nxt = (!has_prev_r && nxt_ok) ? S_RM_PULL_CHK : S_OUT;
      S_RM_PULL_CHK: st_nxt = S_OUT;
      S_FREE_RD:    st_nxt = S_FREE_CHK;
      S_FREE_CHK:   st_nxt = S_FREE_SCAN;
      S_FREE_SCAN: begin
        if (cnt_r == NO_SLOT || !vld_r[cnt_r[AW-1:0]]) st_nxt = S_OUT;
      end
      S_OUT:        st_nxt = S_IDLE;
      default:      st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    free_nxt = free_r; cnt_nxt = cnt_r; cur_nxt = cur_r; prev_nxt = prev_r;
    has_prev_nxt = has_prev_r; at_nxt = at_r;
    ost_nxt = ost_r; ofv_nxt = ofv_r; oslot_nxt = oslot_r; ovalid_nxt = ovalid_r;
    sk_nxt = sk_r; sh_nxt = sh_r; sv_nxt = sv_r; sn_nxt = sn_r; nx_nxt = nx_r;
    we = 1'b0; waddr = '0; wkey = key_r; whash = hash_r; wval = val_r; wnext = NO_SLOT;
    raddr = cur_r; vset = 1'b0; vclr = 1'b0; vaddr = '0;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    case (st_r)
      S_CLEAR: begin
        we = 1'b1; waddr = cnt_r[AW-1:0]; cnt_nxt = cnt_r + 1'b1;
      end
      S_IDLE: begin
        cnt_nxt = '0; has_prev_nxt = 1'b0;
        // result fields hold while a result is still waiting
        if (!ovalid_r) begin
          ost_nxt = ST_DONE; ofv_nxt = '0; oslot_nxt = '0;
        end
      end
      S_RD_MAIN: begin
        raddr = pos; cur_nxt = pos;
      end
      S_CHK_MAIN: begin
        sk_nxt = rkey; sh_nxt = rhash; sv_nxt = rval; sn_nxt = rnext;
        if (!vld_r[pos]) begin
          if (cmd_r[1]) ost_nxt = ST_MISSING;
          else begin
            we = 1'b1; waddr = pos; vset = 1'b1; vaddr = pos; oslot_nxt = pos;
          end
        end else if (rhash[AW-1:0] != pos) begin
          if (cmd_r[1]) ost_nxt = ST_MISSING;
        end
        raddr = pos;
      end
      S_RD_CUR: raddr = cur_r;
      S_CHK_CUR: begin
        raddr = cur_r;
        if (hit) begin
          at_nxt = cur_r; oslot_nxt = cur_r;
          sn_nxt = rnext;
          case (cmd_r)
            CMD_INSERT: ost_nxt = ST_PRESENT;
            CMD_UPSERT: begin
              we = 1'b1; waddr = cur_r; wkey = rkey; whash = rhash; wnext = rnext;
            end
            CMD_LOOKUP: ofv_nxt = VAL_IO_W'({{64{1'b0}}, rval});
            default: ;
          endcase
        end else if (nxt_ok && cnt_r != NO_SLOT - 1'b1) begin
          // keep the predecessor's contents for a later unlink
          sk_nxt = rkey; sh_nxt = rhash; sv_nxt = rval;
          prev_nxt = cur_r; has_prev_nxt = 1'b1;
          cur_nxt = rnext[AW-1:0]; cnt_nxt = cnt_r + 1'b1;
        end else begin
          if (cmd_r[1]) ost_nxt = ST_MISSING;
          cur_nxt = pos; cnt_nxt = '0;
          raddr = pos;
        end
      end
      S_SET_DEC: begin
        raddr = pos;
        if (free_r == NO_SLOT) ost_nxt = ST_FULL;
        else if (rhash[AW-1:0] != pos) begin
          cur_nxt = rhash[AW-1:0]; cnt_nxt = '0;
        end else begin
          cur_nxt = pos; cnt_nxt = '0;
        end
      end
      S_TAIL_RD: raddr = cur_r;
      S_TAIL_CHK: begin
        raddr = cur_r;
        if (nxt_ok && cnt_r != NO_SLOT - 1'b1) begin
          cur_nxt = rnext[AW-1:0]; cnt_nxt = cnt_r + 1'b1;
        end else begin
          // link tail to free slot then place new entry there
          we = 1'b1; waddr = cur_r; wkey = rkey; whash = rhash; wval = rval;
          wnext = free_r;
          sn_nxt = NO_SLOT;
          oslot_nxt = free_r[AW-1:0];
        end
      end
      S_EVICT_RD: raddr = cur_r;
      S_EVICT_CHK: begin
        raddr = cur_r;
        if (rnext == {1'b0, pos}) begin
          we = 1'b1; waddr = cur_r; wkey = rkey; whash = rhash; wval = rval;
          wnext = free_r;
        end else if (rnext < NO_SLOT && cnt_r != NO_SLOT - 1'b1) begin
          cur_nxt = rnext[AW-1:0]; cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EVICT_WR: begin
        // moved occupant lands in the free slot, new entry in main slot next
        we = 1'b1; waddr = free_r[AW-1:0]; wkey = sk_r; whash = sh_r; wval = sv_r;
        wnext = sn_r; vset = 1'b1; vaddr = free_r[AW-1:0];
        oslot_nxt = pos;
      end
      S_RM_DEC: begin
        raddr = sn_r[AW-1:0];
        if (has_prev_r) begin
          we = 1'b1; waddr = prev_r; wnext = sn_r;
          wkey = sk_r; whash = sh_r; wval = sv_r;
        end else if (!nxt_ok) begin
          vclr = 1'b1; vaddr = at_r;
          if (free_r > {1'b0, at_r}) free_nxt = {1'b0, at_r};
        end
        nx_nxt = sn_r[AW-1:0];
      end
      S_RM_PULL_CHK: begin
        raddr = nx_r;
        we = 1'b1; waddr = at_r; wkey = rkey; whash = rhash; wval = rval; wnext = rnext;
        vclr = 1'b1; vaddr = nx_r;
        if (free_r > {1'b0, nx_r}) free_nxt = {1'b0, nx_r};
      end
      S_FREE_RD: raddr = pos;
      S_FREE_CHK: begin
        // final write of the new entry, then search upward for a free slot
        we = 1'b1; waddr = oslot_r; wkey = key_r; whash = hash_r; wval = val_r;
        wnext = NO_SLOT; vset = 1'b1; vaddr = oslot_r;
        cnt_nxt = free_r + 1'b1;
      end
      S_FREE_SCAN: begin
        // one slot per cycle
        if (cnt_r == NO_SLOT) free_nxt = NO_SLOT;
        else if (!vld_r[cnt_r[AW-1:0]]) free_nxt = cnt_r;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_OUT: ovalid_nxt = 1'b1;
      default: ;
    endcase
    // an entry unlinked behind its predecessor is cleared
    if (st_r == S_RM_DEC && has_prev_r) begin
      vclr = 1'b1; vaddr = at_r;
      if (free_r > {1'b0, at_r}) free_nxt = {1'b0, at_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; vld_r <= '0; free_r <= '0; cnt_r <= '0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; free_r <= free_nxt; cnt_r <= cnt_nxt; ovalid_r <= ovalid_nxt;
      if (vset) vld_r[vaddr] <= 1'b1;
      if (vclr) vld_r[vaddr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_ch.valid && in_ch.ready) begin
      cmd_r <= in_ch.command; key_r <= in_ch.key; hash_r <= in_ch.hash;
      val_r <= VALUE_WIDTH'({{64{1'b0}}, in_ch.value});
    end
    cur_r <= cur_nxt; prev_r <= prev_nxt; has_prev_r <= has_prev_nxt; at_r <= at_nxt;
    ost_r <= ost_nxt; ofv_r <= ofv_nxt; oslot_r <= oslot_nxt;
    sk_r <= sk_nxt; sh_r <= sh_nxt; sv_r <= sv_nxt; sn_r <= sn_nxt; nx_r <= nx_nxt;
  end

`ifndef SYNTHESIS
  a_rdy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> st_r == S_IDLE) else $error("ready outside idle");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(st_r) == S_OUT) else $error("result without sequencer");
  a_free_rng: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= NO_SLOT) else $error("free pointer out of range");
`endif
endmodule

// ===== sim/tb_coalesced_hash_table.sv =====
module tb_coalesced_hash_table;
  import cht_pkg::*;

  localparam int CAP = 256;
  localparam int NONE = CAP;
  localparam int POOL_N = 320;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    cmd_t        cmd;
    logic [63:0] key;
    logic [31:0] hash;
    logic [31:0] value;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] found_value;
    logic [7:0]  slot_index;
  } response_t;

  logic clk;
  logic rst_n;

  cht_in_if  in_ch ();
  cht_out_if out_ch ();

  coalesced_hash_table uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the table
  logic        tbl_used [CAP];
  logic [63:0] tbl_key [CAP];
  logic [31:0] tbl_hash [CAP];
  logic [31:0] tbl_val [CAP];
  int          tbl_link [CAP];
  int          free_ptr;

  request_t  pending_reqs [$];
  response_t expected_resp [$];
  int        error_count;
  int        accepted_count;
  int        in_gap;
  int        out_gap;
  int        hold_cycles;
  bit        hold_done;
  int        idle_cycles;

  logic [63:0] pool_key [POOL_N];
  logic [31:0] pool_hash [POOL_N];

  function automatic void table_clear();
    for (int i = 0; i < CAP; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_hash[i] = '0;
      tbl_val[i] = '0;
      tbl_link[i] = NONE;
    end
    free_ptr = 0;
  endfunction

  function automatic void bump_free();
    if (free_ptr >= NONE) return;
    for (int i = free_ptr + 1; i < CAP; i++) begin
      if (!tbl_used[i]) begin
        free_ptr = i;
        return;
      end
    end
    free_ptr = NONE;
  endfunction

  function automatic void drop_free(int s);
    if (free_ptr > s) free_ptr = s;
  endfunction

  function automatic void wipe_slot(int s);
    tbl_used[s] = 1'b0;
    tbl_key[s] = '0;
    tbl_hash[s] = '0;
    tbl_val[s] = '0;
    tbl_link[s] = NONE;
  endfunction

  function automatic void fill_slot(int s, logic [63:0] k, logic [31:0] h, logic [31:0] v);
    tbl_used[s] = 1'b1;
    tbl_key[s] = k;
    tbl_hash[s] = h;
    tbl_val[s] = v;
    tbl_link[s] = NONE;
  endfunction

  // next live link of a chain, or NONE when the chain ends or the link is stale
  function automatic int live_next(int s);
    int n;
    n = tbl_link[s];
    if (n >= NONE || !tbl_used[n]) return NONE;
    return n;
  endfunction

  function automatic bit locate(logic [63:0] k, logic [31:0] h, output int at,
                                output int prev);
    int home;
    int cur;
    home = int'(h[7:0]);
    cur = home;
    prev = NONE;
    at = 0;
    if (!tbl_used[home] || int'(tbl_hash[home][7:0]) != home) return 0;
    for (int steps = 0; steps < CAP; steps++) begin
      if (tbl_hash[cur] == h && tbl_key[cur] == k) begin
        at = cur;
        return 1;
      end
      if (live_next(cur) == NONE) break;
      prev = cur;
      cur = live_next(cur);
    end
    return 0;
  endfunction

  function automatic response_t table_apply(request_t r);
    response_t res;
    int home, at, prev, f, owner, p, nx;
    res.status = ST_DONE;
    res.found_value = '0;
    res.slot_index = '0;
    home = int'(r.hash[7:0]);
    case (r.cmd)
      CMD_INSERT, CMD_UPSERT: begin
        if (!tbl_used[home]) begin
          if (home == free_ptr) bump_free();
          fill_slot(home, r.key, r.hash, r.value);
          res.slot_index = home[7:0];
        end else if (locate(r.key, r.hash, at, prev)) begin
          res.slot_index = at[7:0];
          if (r.cmd == CMD_UPSERT) tbl_val[at] = r.value;
          else res.status = ST_PRESENT;
        end else if (free_ptr >= NONE) begin
          res.status = ST_FULL;
        end else begin
          f = free_ptr;
          owner = int'(tbl_hash[home][7:0]);
          if (owner != home) begin
            // foreign occupant moves out to the free slot
            tbl_used[f] = 1'b1;
            tbl_key[f] = tbl_key[home];
            tbl_hash[f] = tbl_hash[home];
            tbl_val[f] = tbl_val[home];
            tbl_link[f] = tbl_link[home];
            p = owner;
            for (int steps = 0; steps < CAP; steps++) begin
              if (tbl_link[p] == home) begin
                tbl_link[p] = f;
                break;
              end
              if (tbl_link[p] >= NONE) break;
              p = tbl_link[p];
            end
            bump_free();
            fill_slot(home, r.key, r.hash, r.value);
            res.slot_index = home[7:0];
          end else begin
            p = home;
            for (int steps = 0; steps < CAP; steps++) begin
              if (live_next(p) == NONE) break;
              p = live_next(p);
            end
            tbl_link[p] = f;
            bump_free();
            fill_slot(f, r.key, r.hash, r.value);
            res.slot_index = f[7:0];
          end
        end
      end
      CMD_LOOKUP: begin
        if (locate(r.key, r.hash, at, prev)) begin
          res.found_value = tbl_val[at];
          res.slot_index = at[7:0];
        end else begin
          res.status = ST_MISSING;
        end
      end
      default: begin
        if (!locate(r.key, r.hash, at, prev)) begin
          res.status = ST_MISSING;
        end else begin
          res.slot_index = at[7:0];
          nx = live_next(at);
          if (prev != NONE) begin
            tbl_link[prev] = tbl_link[at];
            wipe_slot(at);
            drop_free(at);
          end else if (nx != NONE) begin
            // successor is pulled into the head slot
            tbl_key[at] = tbl_key[nx];
            tbl_hash[at] = tbl_hash[nx];
            tbl_val[at] = tbl_val[nx];
            tbl_link[at] = tbl_link[nx];
            wipe_slot(nx);
            drop_free(nx);
          end else begin
            wipe_slot(at);
            drop_free(at);
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic push_req(cmd_t c, logic [63:0] k, logic [31:0] h, logic [31:0] v);
    request_t r;
    r.cmd = c;
    r.key = k;
    r.hash = h;
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  // one random request; ins_pct and rm_pct steer the table's fill
  task automatic push_random(int ins_pct, int rm_pct);
    int idx, r;
    logic [31:0] h;
    cmd_t c;
    idx = $urandom_range(0, POOL_N - 1);
    h = pool_hash[idx];
    if ($urandom_range(0, 99) < 4) h = $urandom;
    r = $urandom_range(0, 99);
    if (r < ins_pct) c = ($urandom_range(0, 1) != 0) ? CMD_UPSERT : CMD_INSERT;
    else if (r < ins_pct + rm_pct) c = CMD_REMOVE;
    else c = CMD_LOOKUP;
    push_req(c, pool_key[idx], h, $urandom);
  endtask

  always #1 clk = ~clk;

  // driver: predicts on acceptance, then offers the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        request_t acc;
        acc.cmd = cmd_t'(in_ch.command);
        acc.key = in_ch.key;
        acc.hash = in_ch.hash;
        acc.value = in_ch.value;
        expected_resp.push_back(table_apply(acc));
        accepted_count <= accepted_count + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          request_t nxt;
          nxt = pending_reqs.pop_front();
          in_ch.command <= nxt.cmd;
          in_ch.key <= nxt.key;
          in_ch.hash <= nxt.hash;
          in_ch.value <= nxt.value;
          in_ch.valid <= 1'b1;
          in_gap <= ((accepted_count / 150) % 3 == 1) ? 0 : pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and drives the result ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_resp.size() == 0) begin
          $display("%0t: unexpected item status=%0d value=%h slot=%0d", $time,
                   out_ch.status, out_ch.found_value, out_ch.slot_index);
          error_count++;
        end else begin
          response_t e;
          e = expected_resp.pop_front();
          if (out_ch.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_ch.status);
            error_count++;
          end
          if (out_ch.found_value !== e.found_value) begin
            $display("%0t: found_value expected %h actual %h", $time, e.found_value,
                     out_ch.found_value);
            error_count++;
          end
          if (out_ch.slot_index !== e.slot_index) begin
            $display("%0t: slot_index expected %0d actual %0d", $time, e.slot_index,
                     out_ch.slot_index);
            error_count++;
          end
        end
      end
      // one long hold-off mid-run so the input side backs up
      if (!hold_done && accepted_count >= 600) begin
        if (hold_cycles < 400) begin
          hold_cycles <= hold_cycles + 1;
          out_ch.ready <= 1'b0;
        end else begin
          hold_done <= 1'b1;
          out_ch.ready <= 1'b1;
        end
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap <= ((accepted_count / 200) % 2 == 1) ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOOKUP;
    in_ch.key = '0;
    in_ch.hash = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    error_count = 0;
    accepted_count = 0;
    in_gap = 0;
    out_gap = 0;
    hold_cycles = 0;
    hold_done = 1'b0;
    idle_cycles = 0;
    table_clear();

    for (int i = 0; i < POOL_N; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_hash[i] = $urandom;
      if ($urandom_range(0, 1) != 0) pool_hash[i][7:0] = $urandom_range(0, 24);
      // some keys share a full hash with their neighbor
      if (i > 0 && $urandom_range(0, 9) == 0) pool_hash[i] = pool_hash[i - 1];
    end

    // directed: chains, eviction, duplicates, removes, field extremes
    push_req(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h0000_0010, 32'h0000_0000);
    push_req(CMD_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h0000_0010, 32'hffff_ffff);
    push_req(CMD_INSERT, 64'h0, 32'hffff_ff00, 32'h1234_5678);
    push_req(CMD_INSERT, 64'hffff_ffff_ffff_ffff, 32'h0000_0010, 32'h7fff_ffff);
    push_req(CMD_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h0000_0010, 32'h0);
    push_req(CMD_UPSERT, 64'h7fff_ffff_ffff_ffff, 32'h0000_0010, 32'h5555_aaaa);
    push_req(CMD_LOOKUP, 64'h7fff_ffff_ffff_ffff, 32'h0000_0010, 32'h0);
    push_req(CMD_UPSERT, 64'h1, 32'hffff_ffff, 32'hdead_beef);
    push_req(CMD_LOOKUP, 64'h1, 32'hffff_ffff, 32'h0);
    push_req(CMD_LOOKUP, 64'h2, 32'h0000_0010, 32'h0);
    push_req(CMD_LOOKUP, 64'h2, 32'h0000_0077, 32'h0);
    push_req(CMD_REMOVE, 64'h3, 32'h0000_0010, 32'h0);
    push_req(CMD_LOOKUP, 64'h0, 32'h0000_0000, 32'h0);
    push_req(CMD_REMOVE, 64'h8000_0000_0000_0000, 32'h0000_0010, 32'h0);
    push_req(CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'h0000_0010, 32'h0);
    push_req(CMD_REMOVE, 64'h7fff_ffff_ffff_ffff, 32'h0000_0010, 32'h0);
    push_req(CMD_REMOVE, 64'hffff_ffff_ffff_ffff, 32'h0000_0010, 32'h0);
    push_req(CMD_INSERT, 64'h5, 32'h0000_0001, 32'h1);
    push_req(CMD_INSERT, 64'h6, 32'h0000_0001, 32'h2);
    push_req(CMD_INSERT, 64'h7, 32'h0000_0001, 32'h3);
    push_req(CMD_REMOVE, 64'h6, 32'h0000_0001, 32'h0);
    push_req(CMD_LOOKUP, 64'h7, 32'h0000_0001, 32'h0);
    push_req(CMD_REMOVE, 64'h0, 32'hffff_ff00, 32'h0);

    // random: fill up past full, drain, then mixed traffic
    for (int i = 0; i < 380; i++) push_random(85, 5);
    for (int i = 0; i < 330; i++) push_random(25, 55);
    for (int i = 0; i < 340; i++) push_random(45, 25);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || in_ch.valid || expected_resp.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== coalesced_hash_table.f =====
rtl/cht_pkg.sv
rtl/cht_if.sv
rtl/cht_store.sv
rtl/coalesced_hash_table.sv
sim/tb_coalesced_hash_table.sv
